// ===== rtl/lzss_stream_decompressor_defines.svh =====
// assertion macros used by the checker file
// no dependencies; include once per file that asserts
`ifndef LZSS_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_DEFINES_SVH

// same-cycle implication, disabled while rstn is low
`define LZSD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lzsd assertion failed");

// next-cycle implication, disabled while rstn is low
`define LZSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lzsd assertion failed");

`endif

// ===== rtl/lzsd_pkg.sv =====
// shared constants and controller/datapath interface types for the lzss decompressor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lzsd_pkg;

    // defaults for top-level parameters
    localparam int unsigned WINDOW_SIZE_DEF = 4096;
    localparam int unsigned COUNT_BITS_DEF  = 24;

    // field widths
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned INDEX_W     = 24;
    localparam int unsigned LIMIT_W     = 24;
    localparam int unsigned FLAG_W      = 9;
    localparam int unsigned REM_W       = 5;
    localparam int unsigned M_TDATA_W   = 32;

    // match encoding
    localparam int unsigned MIN_MATCH   = 3;
    localparam int unsigned MAX_MATCH   = 18;

    // register file
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;
    localparam logic [0:0]  REG_OUT_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = '1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // input request taken this cycle
        logic rd_issue;  // read window at copy source
        logic emit;      // load output register and write window
        logic clear;     // return stream state to reset values
    } lzsd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_lit;    // current input is a literal
        logic is_copy;   // current input completes a reference
        logic last_item; // latched tlast of the item being emitted
        logic run_end;   // byte being emitted closes the run
        logic out_free;  // output register can take a byte
    } lzsd_stat_t;

endpackage

`default_nettype wire

// ===== rtl/lzsd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lzsd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lzsd_ctrl.sv =====
// sequencing state machine for the lzss decompressor
// depends on lzsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module lzsd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_tlast,
    output logic                    s_tready,
    input  wire lzsd_pkg::lzsd_stat_t stat,
    output lzsd_pkg::lzsd_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LIT  = 4'b0010,
        ST_READ = 4'b0100,
        ST_DATA = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    if (stat.is_lit) begin
                        state_next = ST_LIT;
                    end else if (stat.is_copy) begin
                        state_next = ST_READ;
                    end else begin
                        cmd.clear = s_tlast;
                    end
                end
            end
            ST_LIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.clear  = stat.last_item;
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_DATA;
            end
            ST_DATA: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.run_end) begin
                        cmd.clear  = stat.last_item;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lzsd_dp.sv =====
// decode state, window memory, copy counters and output register
// depends on lzsd_pkg and lzsd_ram
`timescale 1ns / 1ps
`default_nettype none

module lzsd_dp #(
    parameter int unsigned WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF,
    parameter int unsigned COUNT_BITS  = lzsd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire lzsd_pkg::lzsd_cmd_t               cmd,
    output lzsd_pkg::lzsd_stat_t                   stat,
    input  wire logic [lzsd_pkg::BYTE_W-1:0]       in_byte,
    input  wire logic                              in_last,
    input  wire logic [lzsd_pkg::LIMIT_W-1:0]      out_limit,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [lzsd_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tuser
);

    localparam int unsigned WIN_AW = $clog2(WINDOW_SIZE);
    localparam int unsigned FILL_W = WIN_AW + 1;
    localparam int unsigned CMP_W  =
        ((COUNT_BITS > lzsd_pkg::LIMIT_W) ? COUNT_BITS : lzsd_pkg::LIMIT_W) + 1;
    localparam logic [WIN_AW-1:0] WIN_START = WIN_AW'(WINDOW_SIZE - lzsd_pkg::MAX_MATCH);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_SIZE);

    logic [lzsd_pkg::FLAG_W-1:0] flag_shift_reg, flag_shift_next;
    logic                        phase_reg, phase_next;
    logic [lzsd_pkg::BYTE_W-1:0] first_ref_reg, first_ref_next;
    logic [COUNT_BITS-1:0]       count_reg, count_next;
    logic [WIN_AW-1:0]           wr_pos_reg, wr_pos_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [WIN_AW-1:0]           src_reg, src_next;
    logic [lzsd_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic                        copy_mode_reg, copy_mode_next;
    logic                        last_item_reg, last_item_next;
    logic [lzsd_pkg::BYTE_W-1:0] lit_reg, lit_next;
    logic                        rd_hit_reg;
    logic                        m_tvalid_reg;
    logic [lzsd_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                        m_tlast_reg, m_tuser_reg;

    logic [CMP_W-1:0]            cnt_ext, cnt_inc, lim_ext;
    logic                        active, exhausted, limit_hit;
    logic [WIN_AW-1:0]           src_rel;
    logic [lzsd_pkg::BYTE_W-1:0] ram_rd_data, emit_byte;

    // count compare against the limit
    assign cnt_ext   = CMP_W'(count_reg);
    assign cnt_inc   = cnt_ext + CMP_W'(1);
    assign lim_ext   = CMP_W'(out_limit);
    assign active    = (cnt_ext < lim_ext);
    assign limit_hit = (cnt_inc == lim_ext);
    assign exhausted = (flag_shift_reg[lzsd_pkg::FLAG_W-1:1] == '0);

    // classify the input at the port
    assign stat.is_copy   = active && phase_reg;
    assign stat.is_lit    = active && !phase_reg && !exhausted && flag_shift_reg[0];
    assign stat.last_item = last_item_reg;
    assign stat.run_end   = copy_mode_reg ? ((rem_reg == lzsd_pkg::REM_W'(1)) || limit_hit)
                                          : 1'b1;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // unwritten window entries read as zero
    assign src_rel   = src_reg - WIN_START;
    assign emit_byte = copy_mode_reg ? (rd_hit_reg ? ram_rd_data : '0) : lit_reg;

    // stream state update
    always_comb begin
        flag_shift_next = flag_shift_reg;
        phase_next      = phase_reg;
        first_ref_next  = first_ref_reg;
        count_next      = count_reg;
        wr_pos_next     = wr_pos_reg;
        fill_next       = fill_reg;
        src_next        = src_reg;
        rem_next        = rem_reg;
        copy_mode_next  = copy_mode_reg;
        last_item_next  = last_item_reg;
        lit_next        = lit_reg;
        if (cmd.accept && active) begin
            priority if (phase_reg) begin
                src_next        = {in_byte[7:4], first_ref_reg};
                rem_next        = lzsd_pkg::REM_W'(in_byte[3:0])
                                  + lzsd_pkg::REM_W'(lzsd_pkg::MIN_MATCH);
                flag_shift_next = flag_shift_reg >> 1;
                phase_next      = 1'b0;
                copy_mode_next  = 1'b1;
                last_item_next  = in_last;
            end else if (exhausted) begin
                flag_shift_next = {1'b1, in_byte};
            end else if (flag_shift_reg[0]) begin
                lit_next        = in_byte;
                flag_shift_next = flag_shift_reg >> 1;
                copy_mode_next  = 1'b0;
                last_item_next  = in_last;
            end else begin
                first_ref_next  = in_byte;
                phase_next      = 1'b1;
            end
        end
        if (cmd.emit) begin
            count_next  = cnt_inc[COUNT_BITS-1:0];
            wr_pos_next = wr_pos_reg + WIN_AW'(1);
            if (fill_reg != FILL_FULL) begin
                fill_next = fill_reg + FILL_W'(1);
            end
            src_next = src_reg + WIN_AW'(1);
            rem_next = rem_reg - lzsd_pkg::REM_W'(1);
        end
        if (cmd.clear) begin
            flag_shift_next = '0;
            phase_next      = 1'b0;
            first_ref_next  = '0;
            count_next      = '0;
            wr_pos_next     = WIN_START;
            fill_next       = '0;
        end
    end

    // control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_shift_reg <= '0;
            phase_reg      <= 1'b0;
            first_ref_reg  <= '0;
            count_reg      <= '0;
            wr_pos_reg     <= WIN_START;
            fill_reg       <= '0;
            copy_mode_reg  <= 1'b0;
            last_item_reg  <= 1'b0;
        end else begin
            flag_shift_reg <= flag_shift_next;
            phase_reg      <= phase_next;
            first_ref_reg  <= first_ref_next;
            count_reg      <= count_next;
            wr_pos_reg     <= wr_pos_next;
            fill_reg       <= fill_next;
            copy_mode_reg  <= copy_mode_next;
            last_item_reg  <= last_item_next;
        end
    end

    // copy payload registers
    always_ff @(posedge aclk) begin
        src_reg <= src_next;
        rem_reg <= rem_next;
        lit_reg <= lit_next;
        if (cmd.rd_issue) begin
            rd_hit_reg <= ({1'b0, src_rel} < fill_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {cnt_ext[lzsd_pkg::INDEX_W-1:0], emit_byte};
            m_tlast_reg <= stat.run_end;
            m_tuser_reg <= limit_hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // history window
    lzsd_ram #(
        .WIDTH (lzsd_pkg::BYTE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk     (aclk),
        .wr_en   (cmd.emit),
        .wr_addr (wr_pos_reg),
        .wr_data (emit_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (src_reg),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/lzss_stream_decompressor.sv =====
// lzss decompressor top level: register port, controller and datapath
// depends on lzsd_pkg, lzsd_ctrl, lzsd_dp
// a flag byte or first reference byte is taken without leaving idle; a literal
// passes the literal state, which loads its byte into the output register
// a reference gives n output bytes (3..18); each byte is a registered window read in the
// read state, then its write in the data state, since
// a copy may read the byte written just before; a stalled output adds its wait
// synchronous active-low reset; the window reads as zero after reset or tlast
// through a fill count, so no clearing pass and no dead cycles follow either
`timescale 1ns / 1ps
`default_nettype none

module lzss_stream_decompressor #(
    parameter int unsigned WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF,
    parameter int unsigned COUNT_BITS  = lzsd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lzsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [lzsd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lzsd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    // compressed input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lzsd_pkg::BYTE_W-1:0]        s_tdata,  // [7:0] in_byte
    input  wire logic                               s_tlast,
    // decompressed output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [lzsd_pkg::M_TDATA_W-1:0]     m_tdata,  // [7:0] out_byte, [31:8] out_index
    output logic                                    m_tlast,
    output logic                                    m_tuser   // [0] limit_hit
);

    logic [lzsd_pkg::LIMIT_W-1:0] out_limit_reg;
    logic                         reg_sel;
    lzsd_pkg::lzsd_cmd_t          cmd;
    lzsd_pkg::lzsd_stat_t         stat;

    // register decode
    assign pready  = 1'b1;
    assign reg_sel = (paddr[lzsd_pkg::APB_ADDR_W-1:2] == lzsd_pkg::REG_OUT_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_limit_reg <= lzsd_pkg::OUT_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            out_limit_reg <= pwdata[lzsd_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = reg_sel ? lzsd_pkg::APB_DATA_W'(out_limit_reg) : '0;

    // sequencer
    lzsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // decoder datapath
    lzsd_dp #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .out_limit (out_limit_reg),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/lzsd_checker.sv =====
// port-level checks on the lzss decompressor, bound to the top level
// depends on lzss_stream_decompressor_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "lzss_stream_decompressor_defines.svh"

module lzsd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // output register empties on reset
    `LZSD_ASSERT_NEXT(a_rst_empty, aclk, 1'b1, !aresetn, !m_tvalid)

    // a stalled output request keeps its payload
    `LZSD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // the byte that reaches the limit ends its run
    `LZSD_ASSERT_IMP(a_limit_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast)

    // no new input while a reference run is unfinished
    `LZSD_ASSERT_IMP(a_busy_mid_run, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)

endmodule

bind lzss_stream_decompressor lzsd_checker u_lzsd_checker (.*);

`default_nettype wire
